// ===== rtl/ijtp_pkg.sv =====
// ----------------------------------------------------------------------------
// ijtp_pkg
// Shared types, codes and decode helpers of the indirect jump target profiler.
// ----------------------------------------------------------------------------
package ijtp_pkg;

  localparam int PC_W    = 64;
  localparam int WORD_W  = 32;
  localparam int REG_W   = 5;
  localparam int CNT_W   = 64;
  localparam int DIST_W  = 4;
  localparam int STAT_W  = 3;
  localparam int JSLOT_W = 4;
  localparam int TSLOT_W = 3;

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_EVENT     = 2'd0,
    OP_READ_JUMP = 2'd1,
    OP_READ_SLOT = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_JUMP   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_SLOTS_FULL = 3'd3,
    ST_EMPTY_READ = 3'd4
  } status_t;

  // Return forms that are excluded from profiling.
  localparam logic [WORD_W-1:0] RET_C_JR_RA = 32'h0000_8082;
  localparam logic [WORD_W-1:0] RET_JALR_RA = 32'h0000_8067;

  localparam logic [WORD_W-1:0] MAJOR_MASK = 32'h0000_007f;
  localparam logic [WORD_W-1:0] MAJOR_JALR = 32'h0000_0067;
  localparam logic [WORD_W-1:0] IMM_MASK   = 32'hfff0_0000;
  localparam logic [WORD_W-1:0] CR_MASK    = 32'h0000_f07f;
  localparam logic [WORD_W-1:0] CR_JR      = 32'h0000_8002;
  localparam logic [WORD_W-1:0] CR_JALR    = 32'h0000_9002;

  // Write controls of the jump entry table.
  typedef struct packed {
    logic wr;
    logic alloc;
  } jt_ctl_t;

  // Write controls of the target slot table.
  typedef struct packed {
    logic wr;
    logic clear_row;
  } st_ctl_t;

  function automatic logic is_indirect(input logic [WORD_W-1:0] w);
    logic jalr0;
    logic cjr;
    if (w == RET_C_JR_RA || w == RET_JALR_RA) begin
      return 1'b0;
    end
    jalr0 = ((w & MAJOR_MASK) == MAJOR_JALR) && ((w & IMM_MASK) == '0);
    cjr   = ((w & CR_MASK) == CR_JR) || ((w & CR_MASK) == CR_JALR);
    return jalr0 || cjr;
  endfunction

  // Full-size encodings carry rs1 at [19:15], compressed ones at [11:7].
  function automatic logic [REG_W-1:0] decode_reg(input logic [WORD_W-1:0] w);
    if (w[1:0] == 2'b11) begin
      return w[19:15];
    end
    return w[11:7];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    if (v == '1) begin
      return v;
    end
    return v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/ijtp_jump_tab.sv =====
// ----------------------------------------------------------------------------
// ijtp_jump_tab
// Jump entry table: pc tag match with lowest-free search, one read port and
// one write port.
// ----------------------------------------------------------------------------
module ijtp_jump_tab #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4,
  parameter int TOT_W   = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ijtp_pkg::PC_W-1:0]    lk_pc,
  output logic                         lk_hit,
  output logic [IDX_W-1:0]             lk_hit_idx,
  output logic                         lk_free,
  output logic [IDX_W-1:0]             lk_free_idx,
  input  logic [IDX_W-1:0]             rd_idx,
  output logic                         rd_used,
  output logic [ijtp_pkg::PC_W-1:0]    rd_addr,
  output logic [ijtp_pkg::REG_W-1:0]   rd_reg,
  output logic [ijtp_pkg::CNT_W-1:0]   rd_exec,
  output logic [TOT_W-1:0]             rd_total,
  input  ijtp_pkg::jt_ctl_t            ctl,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [ijtp_pkg::PC_W-1:0]    wr_addr,
  input  logic [ijtp_pkg::REG_W-1:0]   wr_reg,
  input  logic [ijtp_pkg::CNT_W-1:0]   wr_exec,
  input  logic [TOT_W-1:0]             wr_total
);
  import ijtp_pkg::*;

  logic [ENTRIES-1:0] used_r;
  logic [PC_W-1:0]    addr_r  [ENTRIES];
  logic [REG_W-1:0]   reg_r   [ENTRIES];
  logic [CNT_W-1:0]   exec_r  [ENTRIES];
  logic [TOT_W-1:0]   total_r [ENTRIES];

  // Lowest matching entry and lowest free entry.
  always_comb begin
    lk_hit      = 1'b0;
    lk_hit_idx  = '0;
    lk_free     = 1'b0;
    lk_free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (used_r[i] && (addr_r[i] == lk_pc) && !lk_hit) begin
        lk_hit     = 1'b1;
        lk_hit_idx = IDX_W'(i);
      end
      if (!used_r[i] && !lk_free) begin
        lk_free     = 1'b1;
        lk_free_idx = IDX_W'(i);
      end
    end
  end

  assign rd_used  = used_r[rd_idx];
  assign rd_addr  = addr_r[rd_idx];
  assign rd_reg   = reg_r[rd_idx];
  assign rd_exec  = exec_r[rd_idx];
  assign rd_total = total_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctl.wr) begin
      used_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      if (ctl.alloc) begin
        addr_r[wr_idx] <= wr_addr;
      end
      reg_r[wr_idx]   <= wr_reg;
      exec_r[wr_idx]  <= wr_exec;
      total_r[wr_idx] <= wr_total;
    end
  end

endmodule

// ===== rtl/ijtp_slot_tab.sv =====
// ----------------------------------------------------------------------------
// ijtp_slot_tab
// Target slot table: one row of slots per jump entry, target match and
// lowest-free search across the selected row.
// ----------------------------------------------------------------------------
module ijtp_slot_tab #(
  parameter int ROWS   = 16,
  parameter int SLOTS  = 8,
  parameter int ROW_W  = 4,
  parameter int SLOT_W = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ROW_W-1:0]             rd_row,
  input  logic                         row_fresh,
  input  logic [ijtp_pkg::PC_W-1:0]    lk_tgt,
  output logic                         lk_hit,
  output logic [SLOT_W-1:0]            lk_hit_slot,
  output logic                         lk_free,
  output logic [SLOT_W-1:0]            lk_free_slot,
  input  logic [SLOT_W-1:0]            rd_slot,
  output logic                         rd_used,
  output logic [ijtp_pkg::PC_W-1:0]    rd_addr,
  output logic [ijtp_pkg::CNT_W-1:0]   rd_hits,
  input  ijtp_pkg::st_ctl_t            ctl,
  input  logic [ROW_W-1:0]             wr_row,
  input  logic [SLOT_W-1:0]            wr_slot,
  input  logic [ijtp_pkg::PC_W-1:0]    wr_addr,
  input  logic [ijtp_pkg::CNT_W-1:0]   wr_hits
);
  import ijtp_pkg::*;

  logic [SLOTS-1:0]            used_r [ROWS];
  logic [SLOTS-1:0][PC_W-1:0]  addr_r [ROWS];
  logic [SLOTS-1:0][CNT_W-1:0] hits_r [ROWS];
  logic [SLOTS-1:0]            row_used;

  // A row that is being allocated in this pass counts as empty.
  assign row_used = row_fresh ? '0 : used_r[rd_row];

  always_comb begin
    lk_hit       = 1'b0;
    lk_hit_slot  = '0;
    lk_free      = 1'b0;
    lk_free_slot = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (row_used[j] && (addr_r[rd_row][j] == lk_tgt) && !lk_hit) begin
        lk_hit      = 1'b1;
        lk_hit_slot = SLOT_W'(j);
      end
      if (!row_used[j] && !lk_free) begin
        lk_free      = 1'b1;
        lk_free_slot = SLOT_W'(j);
      end
    end
  end

  assign rd_used = used_r[rd_row][rd_slot];
  assign rd_addr = addr_r[rd_row][rd_slot];
  assign rd_hits = hits_r[rd_row][rd_slot];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        used_r[r] <= '0;
      end
    end else begin
      if (ctl.clear_row) begin
        // A fresh row keeps only the slot written in the same cycle.
        used_r[wr_row] <= ctl.wr ? (SLOTS'(1) << wr_slot) : '0;
      end else if (ctl.wr) begin
        used_r[wr_row][wr_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      addr_r[wr_row][wr_slot] <= wr_addr;
      hits_r[wr_row][wr_slot] <= wr_hits;
    end
  end

endmodule

// ===== rtl/indirect_jump_target_profiler.sv =====
// ----------------------------------------------------------------------------
// indirect_jump_target_profiler
// Profiles indirect jumps of a retired RISC-V instruction stream: per-pc
// execution counts, distinct targets and per-target hit counts.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_ stream: in_tuser carries the operation (a
// retired instruction event, a jump entry read or a target slot read) and
// in_tdata the pc, the instruction word, the rs1 value and the read indices.
// Every item gives exactly one result on the out_ stream: out_tuser carries
// the status and the slot valid flag, out_tdata the entry and slot fields.
// Path: an accepted item is held in the input register, then the lookup and
// update logic loads its result into the output register, which drives
// out_tvalid. Throughput is one item per cycle while out_tready does not
// stall the output register; the tables are updated at the same edge that
// loads the result, so the next item already sees the updated counters.
// Reset empties both stages and clears the valid bits of the jump entries
// and target slots at once; no clearing pass is needed.
// When the receiver holds out_tready low, the result stays in the output
// register and one further item may wait in the input register; in_tready
// falls only when both are occupied.
// ----------------------------------------------------------------------------
module indirect_jump_target_profiler #(
  parameter int JUMP_ENTRIES     = 16,
  parameter int TARGETS_PER_JUMP = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] opcode
  input  logic [1:0]   in_tuser,
  // [63:0] instr_pc, [95:64] instr_word, [159:96] rs1_value,
  // [163:160] jump_slot, [166:164] target_slot, [167] zero
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [3] slot_valid
  output logic [3:0]   out_tuser,
  // [63:0] entry_pc, [68:64] entry_reg, [132:69] run_count,
  // [136:133] distinct_targets, [200:137] target_pc, [264:201] target_hits,
  // [271:265] zero
  output logic [271:0] out_tdata
);
  import ijtp_pkg::*;

  localparam int JIDX_W = (JUMP_ENTRIES > 1) ? $clog2(JUMP_ENTRIES) : 1;
  localparam int TIDX_W = (TARGETS_PER_JUMP > 1) ? $clog2(TARGETS_PER_JUMP) : 1;
  localparam int TOT_W  = $clog2(TARGETS_PER_JUMP + 1);

  // --------------------------------------------------------------------------
  // Handshake. The input register advances whenever the output register is
  // empty or being drained in this cycle.
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic fire;
  logic in_take;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Input register.
  // --------------------------------------------------------------------------
  logic [1:0]         s1_op_r;
  logic [PC_W-1:0]    s1_pc_r;
  logic [WORD_W-1:0]  s1_word_r;
  logic [PC_W-1:0]    s1_rs1_r;
  logic [JSLOT_W-1:0] s1_js_r;
  logic [TSLOT_W-1:0] s1_ts_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_tuser;
      s1_pc_r   <= in_tdata[63:0];
      s1_word_r <= in_tdata[95:64];
      s1_rs1_r  <= in_tdata[159:96];
      s1_js_r   <= in_tdata[163:160];
      s1_ts_r   <= in_tdata[166:164];
    end
  end

  // --------------------------------------------------------------------------
  // Decode and read indices.
  // --------------------------------------------------------------------------
  logic              is_event;
  logic              is_jump;
  logic [REG_W-1:0]  src_reg;
  logic              js_ok;
  logic              ts_ok;
  logic [JIDX_W+JSLOT_W-1:0] js_wide;
  logic [TIDX_W+TSLOT_W-1:0] ts_wide;
  logic [JIDX_W-1:0] js_idx;
  logic [TIDX_W-1:0] ts_idx;

  assign is_event = (op_t'(s1_op_r) == OP_EVENT);
  assign is_jump  = is_indirect(s1_word_r);
  assign src_reg  = decode_reg(s1_word_r);
  assign js_ok    = 32'(s1_js_r) < 32'(JUMP_ENTRIES);
  assign ts_ok    = 32'(s1_ts_r) < 32'(TARGETS_PER_JUMP);
  assign js_wide  = (JIDX_W + JSLOT_W)'(s1_js_r);
  assign ts_wide  = (TIDX_W + TSLOT_W)'(s1_ts_r);
  assign js_idx   = js_wide[JIDX_W-1:0];
  assign ts_idx   = ts_wide[TIDX_W-1:0];

  // --------------------------------------------------------------------------
  // Jump entry table.
  // --------------------------------------------------------------------------
  logic              jt_hit, jt_free;
  logic [JIDX_W-1:0] jt_hit_idx, jt_free_idx;
  logic [JIDX_W-1:0] jt_rd_idx;
  logic              jt_rd_used;
  logic [PC_W-1:0]   jt_rd_addr;
  logic [REG_W-1:0]  jt_rd_reg;
  logic [CNT_W-1:0]  jt_rd_exec;
  logic [TOT_W-1:0]  jt_rd_total;
  jt_ctl_t           jt_ctl;
  logic [JIDX_W-1:0] ev_row;
  logic              ev_alloc;
  logic [CNT_W-1:0]  exec_new;
  logic [TOT_W-1:0]  total_base;
  logic [TOT_W-1:0]  total_new;

  // An event works on its matching entry, or else on the lowest free one.
  assign ev_row    = jt_hit ? jt_hit_idx : jt_free_idx;
  assign ev_alloc  = !jt_hit && jt_free;
  assign jt_rd_idx = is_event ? ev_row : js_idx;

  ijtp_jump_tab #(
    .ENTRIES (JUMP_ENTRIES),
    .IDX_W   (JIDX_W),
    .TOT_W   (TOT_W)
  ) u_jump_tab (
    .clk         (clk),
    .rst_n       (rst_n),
    .lk_pc       (s1_pc_r),
    .lk_hit      (jt_hit),
    .lk_hit_idx  (jt_hit_idx),
    .lk_free     (jt_free),
    .lk_free_idx (jt_free_idx),
    .rd_idx      (jt_rd_idx),
    .rd_used     (jt_rd_used),
    .rd_addr     (jt_rd_addr),
    .rd_reg      (jt_rd_reg),
    .rd_exec     (jt_rd_exec),
    .rd_total    (jt_rd_total),
    .ctl         (jt_ctl),
    .wr_idx      (ev_row),
    .wr_addr     (s1_pc_r),
    .wr_reg      (src_reg),
    .wr_exec     (exec_new),
    .wr_total    (total_new)
  );

  // --------------------------------------------------------------------------
  // Target slot table. A freshly allocated entry sees an empty row.
  // --------------------------------------------------------------------------
  logic              st_hit, st_free;
  logic [TIDX_W-1:0] st_hit_slot, st_free_slot;
  logic [TIDX_W-1:0] ev_slot;
  logic [TIDX_W-1:0] st_rd_slot;
  logic              st_rd_used;
  logic [PC_W-1:0]   st_rd_addr;
  logic [CNT_W-1:0]  st_rd_hits;
  st_ctl_t           st_ctl;
  logic              slot_new;
  logic              slot_ok;
  logic [CNT_W-1:0]  hits_new;

  assign ev_slot    = st_hit ? st_hit_slot : st_free_slot;
  assign st_rd_slot = is_event ? ev_slot : ts_idx;
  assign slot_new   = !st_hit && st_free;
  assign slot_ok    = st_hit || st_free;

  ijtp_slot_tab #(
    .ROWS   (JUMP_ENTRIES),
    .SLOTS  (TARGETS_PER_JUMP),
    .ROW_W  (JIDX_W),
    .SLOT_W (TIDX_W)
  ) u_slot_tab (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_row       (jt_rd_idx),
    .row_fresh    (is_event && ev_alloc),
    .lk_tgt       (s1_rs1_r),
    .lk_hit       (st_hit),
    .lk_hit_slot  (st_hit_slot),
    .lk_free      (st_free),
    .lk_free_slot (st_free_slot),
    .rd_slot      (st_rd_slot),
    .rd_used      (st_rd_used),
    .rd_addr      (st_rd_addr),
    .rd_hits      (st_rd_hits),
    .ctl          (st_ctl),
    .wr_row       (ev_row),
    .wr_slot      (ev_slot),
    .wr_addr      (s1_rs1_r),
    .wr_hits      (hits_new)
  );

  // --------------------------------------------------------------------------
  // Counter updates. A new entry starts from zero, so its first execution
  // reads as one.
  // --------------------------------------------------------------------------
  logic ev_ok_entry;
  logic ev_commit;

  assign exec_new   = ev_alloc ? CNT_W'(1) : sat_inc(jt_rd_exec);
  assign total_base = ev_alloc ? '0 : jt_rd_total;
  assign total_new  = (slot_new && (32'(total_base) < 32'(TARGETS_PER_JUMP)))
                      ? total_base + TOT_W'(1) : total_base;
  assign hits_new   = slot_new ? CNT_W'(1) : sat_inc(st_rd_hits);

  assign ev_ok_entry = jt_hit || jt_free;
  assign ev_commit   = fire && is_event && is_jump && ev_ok_entry;

  always_comb begin
    jt_ctl.wr        = ev_commit;
    jt_ctl.alloc     = ev_commit && ev_alloc;
    st_ctl.clear_row = ev_commit && ev_alloc;
    st_ctl.wr        = ev_commit && slot_ok;
  end

  // Distinct target count shown saturated at fifteen.
  function automatic logic [DIST_W-1:0] dist_view(input logic [TOT_W-1:0] t);
    logic [TOT_W+DIST_W-1:0] wide;
    wide = (TOT_W + DIST_W)'(t);
    if (wide > (TOT_W + DIST_W)'(15)) begin
      return '1;
    end
    return wide[DIST_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Result selection.
  // --------------------------------------------------------------------------
  status_t           res_status;
  logic [PC_W-1:0]   res_pc;
  logic [REG_W-1:0]  res_reg;
  logic [CNT_W-1:0]  res_total;
  logic [DIST_W-1:0] res_dist;
  logic [PC_W-1:0]   res_addr;
  logic [CNT_W-1:0]  res_hits;
  logic              res_valid;

  always_comb begin
    res_status = ST_OK;
    res_pc     = '0;
    res_reg    = '0;
    res_total  = '0;
    res_dist   = '0;
    res_addr   = '0;
    res_hits   = '0;
    res_valid  = 1'b0;
    case (op_t'(s1_op_r))
      OP_EVENT: begin
        if (!is_jump) begin
          res_status = ST_NOT_JUMP;
        end else if (!ev_ok_entry) begin
          // Table full: the event is dropped.
          res_status = ST_TABLE_FULL;
          res_pc     = s1_pc_r;
          res_reg    = src_reg;
        end else begin
          res_pc    = s1_pc_r;
          res_reg   = src_reg;
          res_total = exec_new;
          res_dist  = dist_view(total_new);
          res_addr  = s1_rs1_r;
          if (slot_ok) begin
            res_status = ST_OK;
            res_hits   = hits_new;
            res_valid  = 1'b1;
          end else begin
            // Execution counted, target not recorded.
            res_status = ST_SLOTS_FULL;
          end
        end
      end
      OP_READ_JUMP: begin
        if (js_ok && jt_rd_used) begin
          res_pc    = jt_rd_addr;
          res_reg   = jt_rd_reg;
          res_total = jt_rd_exec;
          res_dist  = dist_view(jt_rd_total);
          res_valid = 1'b1;
        end else begin
          res_status = ST_EMPTY_READ;
        end
      end
      OP_READ_SLOT: begin
        if (js_ok && ts_ok && jt_rd_used && st_rd_used) begin
          res_pc    = jt_rd_addr;
          res_reg   = jt_rd_reg;
          res_total = jt_rd_exec;
          res_dist  = dist_view(jt_rd_total);
          res_addr  = st_rd_addr;
          res_hits  = st_rd_hits;
          res_valid = 1'b1;
        end else begin
          res_status = ST_EMPTY_READ;
        end
      end
      default: begin
        // The spare operation code changes nothing.
        res_status = ST_NOT_JUMP;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  status_t           o_status_r;
  logic [PC_W-1:0]   o_pc_r;
  logic [REG_W-1:0]  o_reg_r;
  logic [CNT_W-1:0]  o_total_r;
  logic [DIST_W-1:0] o_dist_r;
  logic [PC_W-1:0]   o_addr_r;
  logic [CNT_W-1:0]  o_hits_r;
  logic              o_valid_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      o_status_r <= res_status;
      o_pc_r     <= res_pc;
      o_reg_r    <= res_reg;
      o_total_r  <= res_total;
      o_dist_r   <= res_dist;
      o_addr_r   <= res_addr;
      o_hits_r   <= res_hits;
      o_valid_r  <= res_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {o_valid_r, o_status_r};
  assign out_tdata  = {7'd0, o_hits_r, o_addr_r, o_dist_r, o_total_r, o_reg_r, o_pc_r};

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indirect jump target profiler. Random and
// directed retire events and table reads are sent with random gaps. Every
// result transfer is checked against a bit-accurate profile kept in the
// bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ijtp_pkg::*;

  localparam int N_JUMPS       = 16;
  localparam int N_TARGETS     = 8;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PC_POOL       = 20;
  localparam int TARGET_POOL   = 12;

  // Opcode 3 has no meaning; the block must ignore it.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Encoding fragments used both to build jumps and to classify them.
  localparam logic [6:0] JALR_MAJOR    = 7'b110_0111;
  localparam logic [6:0] CR_QUADRANT   = 7'b000_0010;
  localparam logic [3:0] CR_JR_FUNCT   = 4'b1000;
  localparam logic [3:0] CR_JALR_FUNCT = 4'b1001;

  typedef enum int {
    FORM_JALR,
    FORM_CJR,
    FORM_CJALR
  } jump_form_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] pc;
    logic [31:0] word;
    logic [63:0] rs1;
    logic [3:0]  jslot;
    logic [2:0]  tslot;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] entry_pc;
    logic [4:0]  entry_reg;
    logic [63:0] total;
    logic [3:0]  distinct;
    logic [63:0] target_pc;
    logic [63:0] target_hits;
    logic        valid;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the jump and target tables, works out
  // the result of every accepted input transfer and checks result transfers
  // against the oldest outstanding prediction.
  // --------------------------------------------------------------------------
  class profile_scoreboard;
    bit          jump_used    [N_JUMPS];
    logic [63:0] jump_pc      [N_JUMPS];
    logic [4:0]  jump_reg     [N_JUMPS];
    logic [63:0] jump_execs   [N_JUMPS];
    logic [3:0]  jump_targets [N_JUMPS];
    bit          slot_used    [N_JUMPS][N_TARGETS];
    logic [63:0] slot_addr    [N_JUMPS][N_TARGETS];
    logic [63:0] slot_hits    [N_JUMPS][N_TARGETS];
    result_t     expected_results [$];
    int          faults;

    function logic [63:0] count_up(logic [63:0] v);
      return (&v) ? v : v + 64'd1;
    endfunction

    // Returns are excluded by their exact 32-bit encodings only.
    function bit is_profiled(logic [31:0] w);
      if (w == RET_C_JR_RA || w == RET_JALR_RA) begin
        return 1'b0;
      end
      if (w[6:0] == JALR_MAJOR && w[31:20] == 12'h000) begin
        return 1'b1;
      end
      return w[6:0] == CR_QUADRANT &&
             (w[15:12] == CR_JR_FUNCT || w[15:12] == CR_JALR_FUNCT);
    endfunction

    function result_t entry_view(int e);
      result_t r;
      r           = '0;
      r.entry_pc  = jump_pc[e];
      r.entry_reg = jump_reg[e];
      r.total     = jump_execs[e];
      r.distinct  = jump_targets[e];
      return r;
    endfunction

    function result_t record_jump(item_t it);
      result_t    r;
      int         hit;
      int         spare;
      int         slot_hit;
      int         slot_spare;
      logic [4:0] rs;
      r = '0;
      if (!is_profiled(it.word)) begin
        r.status = ST_NOT_JUMP;
        return r;
      end
      // Full-size encodings hold rs1 in bits 19:15, compressed ones in 11:7.
      rs    = (it.word[1:0] == 2'b11) ? it.word[19:15] : it.word[11:7];
      hit   = -1;
      spare = -1;
      for (int e = 0; e < N_JUMPS; e++) begin
        if (jump_used[e]) begin
          if (hit < 0 && jump_pc[e] == it.pc) hit = e;
        end else if (spare < 0) begin
          spare = e;
        end
      end
      if (hit < 0) begin
        if (spare < 0) begin
          r.status    = ST_TABLE_FULL;
          r.entry_pc  = it.pc;
          r.entry_reg = rs;
          return r;
        end
        hit               = spare;
        jump_used[hit]    = 1'b1;
        jump_pc[hit]      = it.pc;
        jump_execs[hit]   = '0;
        jump_targets[hit] = '0;
        for (int s = 0; s < N_TARGETS; s++) slot_used[hit][s] = 1'b0;
      end
      jump_reg[hit]   = rs;
      jump_execs[hit] = count_up(jump_execs[hit]);

      slot_hit   = -1;
      slot_spare = -1;
      for (int s = 0; s < N_TARGETS; s++) begin
        if (slot_used[hit][s]) begin
          if (slot_hit < 0 && slot_addr[hit][s] == it.rs1) slot_hit = s;
        end else if (slot_spare < 0) begin
          slot_spare = s;
        end
      end
      if (slot_hit < 0) begin
        if (slot_spare < 0) begin
          // The execution still counts, but the target has nowhere to go.
          r           = entry_view(hit);
          r.status    = ST_SLOTS_FULL;
          r.target_pc = it.rs1;
          return r;
        end
        slot_hit                     = slot_spare;
        slot_used[hit][slot_hit]     = 1'b1;
        slot_addr[hit][slot_hit]     = it.rs1;
        slot_hits[hit][slot_hit]     = '0;
        if (jump_targets[hit] < N_TARGETS) jump_targets[hit]++;
      end
      slot_hits[hit][slot_hit] = count_up(slot_hits[hit][slot_hit]);
      r             = entry_view(hit);
      r.target_pc   = slot_addr[hit][slot_hit];
      r.target_hits = slot_hits[hit][slot_hit];
      r.valid       = 1'b1;
      return r;
    endfunction

    function result_t profile_step(item_t it);
      result_t r;
      r = '0;
      case (it.op)
        OP_EVENT: r = record_jump(it);
        OP_READ_JUMP: begin
          if (jump_used[it.jslot]) begin
            r       = entry_view(it.jslot);
            r.valid = 1'b1;
          end else begin
            r.status = ST_EMPTY_READ;
          end
        end
        OP_READ_SLOT: begin
          if (jump_used[it.jslot] && slot_used[it.jslot][it.tslot]) begin
            r             = entry_view(it.jslot);
            r.target_pc   = slot_addr[it.jslot][it.tslot];
            r.target_hits = slot_hits[it.jslot][it.tslot];
            r.valid       = 1'b1;
          end else begin
            r.status = ST_EMPTY_READ;
          end
        end
        default: r.status = ST_NOT_JUMP;
      endcase
      return r;
    endfunction

    function void note_item(item_t it);
      expected_results.push_back(profile_step(it));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        faults++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with no prediction, expected none actual status %0d",
                 $time, got.status);
        faults++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("entry_pc", want.entry_pc, got.entry_pc);
      compare_field("entry_reg", 64'(want.entry_reg), 64'(got.entry_reg));
      compare_field("run_count", want.total, got.total);
      compare_field("distinct_targets", 64'(want.distinct), 64'(got.distinct));
      compare_field("target_pc", want.target_pc, got.target_pc);
      compare_field("target_hits", want.target_hits, got.target_hits);
      compare_field("slot_valid", 64'(want.valid), 64'(got.valid));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser   = '0;
  logic [167:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [3:0]   out_tuser;
  logic [271:0] out_tdata;

  profile_scoreboard sb = new;
  int cycles        = 0;
  int items_sent    = 0;
  int results_taken = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  indirect_jump_target_profiler #(
    .JUMP_ENTRIES     (N_JUMPS),
    .TARGETS_PER_JUMP (N_TARGETS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // A generous cycle budget; a run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Transfer monitor. Both channels are sampled at the rising edge, so the
  // values seen are the ones that took part in the handshake. A result can
  // never belong to an input accepted at the same edge, so checking first
  // and predicting second is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    item_t   took;
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status      = status_t'(out_tuser[2:0]);
        got.valid       = out_tuser[3];
        got.entry_pc    = out_tdata[63:0];
        got.entry_reg   = out_tdata[68:64];
        got.total       = out_tdata[132:69];
        got.distinct    = out_tdata[136:133];
        got.target_pc   = out_tdata[200:137];
        got.target_hits = out_tdata[264:201];
        sb.check_result(got);
      end
      if (in_tvalid && in_tready) begin
        took.op    = in_tuser;
        took.pc    = in_tdata[63:0];
        took.word  = in_tdata[95:64];
        took.rs1   = in_tdata[159:96];
        took.jslot = in_tdata[163:160];
        took.tslot = in_tdata[166:164];
        sb.note_item(took);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink. Before each result it may stall by holding out_tready low;
  // every so often it runs a stretch with no stalls at all.
  // out_tready is only ever lowered in a cycle where it is not also raised.
  // --------------------------------------------------------------------------
  initial begin : sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (results_taken % 60 >= 40) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Sends one item, after a random gap unless in a burst stretch, and returns
  // at the edge where the transfer happens. tvalid stays high when the next
  // item follows at once.
  task automatic send_item(input item_t it);
    int gap;
    gap = (items_sent % 72 >= 48) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {1'b0, it.tslot, it.jslot, it.rs1, it.word, it.pc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Fields that an operation does not use still carry random values, so
  // that the block is seen to ignore them.
  function automatic item_t random_item(logic [1:0] op);
    item_t it;
    it.op    = op;
    it.pc    = {$urandom, $urandom};
    it.word  = $urandom;
    it.rs1   = {$urandom, $urandom};
    it.jslot = 4'($urandom_range(0, N_JUMPS - 1));
    it.tslot = 3'($urandom_range(0, N_TARGETS - 1));
    return it;
  endfunction

  function automatic item_t jump_event(logic [63:0] pc, logic [31:0] word,
                                       logic [63:0] target);
    item_t it;
    it      = random_item(OP_EVENT);
    it.pc   = pc;
    it.word = word;
    it.rs1  = target;
    return it;
  endfunction

  function automatic item_t table_read(logic [1:0] op, int js, int ts);
    item_t it;
    it       = random_item(op);
    it.jslot = 4'(js);
    it.tslot = 3'(ts);
    return it;
  endfunction

  // Builds a jump of the given form. Compressed forms may carry junk in the
  // upper half, which the classification does not look at.
  function automatic logic [31:0] jump_word(jump_form_t form, logic [4:0] rs,
                                            bit high_junk);
    logic [15:0] upper;
    upper = high_junk ? 16'($urandom) : 16'h0000;
    case (form)
      FORM_JALR: return {12'h000, rs, 3'($urandom), 5'($urandom), JALR_MAJOR};
      FORM_CJR:  return {upper, CR_JR_FUNCT, rs, CR_QUADRANT};
      default:   return {upper, CR_JALR_FUNCT, rs, CR_QUADRANT};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence: reset, a short directed part, then random traffic drawn
  // mostly from small pools of pcs and targets so that entries repeat, the
  // target slots of hot jumps overflow and the jump table fills up.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    item_t       it;
    logic [63:0] pc_pool     [PC_POOL];
    logic [63:0] target_pool [TARGET_POOL];
    int          sent;
    int          roll;
    int          pick;
    bit          drained;

    for (int i = 0; i < PC_POOL; i++) pc_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < TARGET_POOL; i++) target_pool[i] = {$urandom, $urandom};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reads of an empty table.
    send_item(table_read(OP_READ_JUMP, 0, 0));
    send_item(table_read(OP_READ_SLOT, N_JUMPS - 1, N_TARGETS - 1));
    // Both return forms and a jalr with a non-zero offset are not profiled.
    send_item(jump_event(pc_pool[0], RET_C_JR_RA, target_pool[0]));
    send_item(jump_event(pc_pool[0], RET_JALR_RA, target_pool[0]));
    send_item(jump_event(pc_pool[0], {12'h004, 5'd1, 3'b000, 5'd0, JALR_MAJOR},
                         target_pool[0]));
    // An unused opcode carrying a valid jump must leave the tables alone.
    it    = jump_event('1, jump_word(FORM_CJALR, 5'd5, 1'b0), '1);
    it.op = OP_IGNORED;
    send_item(it);
    // Extreme pc and target: allocation, then a second hit on the same slot.
    send_item(jump_event('1, {12'h000, 5'd5, 3'b000, 5'd1, JALR_MAJOR}, '1));
    send_item(jump_event('1, {12'h000, 5'd5, 3'b000, 5'd1, JALR_MAJOR}, '1));
    // Zero pc via c.jr x31, then c.jalr x7 with junk upper bits on the same
    // pc: the source register is rewritten and a second target is added.
    send_item(jump_event('0, jump_word(FORM_CJR, 5'd31, 1'b0), '0));
    send_item(jump_event('0, {16'hffff, CR_JALR_FUNCT, 5'd7, CR_QUADRANT}, 64'd1));
    // c.jr x0 is reserved, but its encoding still counts as a jump.
    send_item(jump_event(64'h1000, jump_word(FORM_CJR, 5'd0, 1'b0), 64'h2000));
    // One more distinct target than there are slots, on a fresh entry.
    for (int t = 0; t <= N_TARGETS; t++) begin
      send_item(jump_event(64'h8000_0000, jump_word(FORM_CJALR, 5'd10, 1'b0),
                           64'h4000 + 64'(t) * 64'd8));
    end
    send_item(table_read(OP_READ_JUMP, 3, 0));
    send_item(table_read(OP_READ_SLOT, 3, N_TARGETS - 1));
    send_item(table_read(OP_READ_SLOT, 0, 0));

    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // Well-formed jump, biased towards a few hot pcs.
        pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                           : $urandom_range(0, PC_POOL - 1);
        it = jump_event(pc_pool[pick],
                        jump_word(jump_form_t'($urandom_range(0, 2)), 5'($urandom),
                                  $urandom_range(0, 7) == 0),
                        target_pool[$urandom_range(0, TARGET_POOL - 1)]);
        if ($urandom_range(0, 19) == 0) it.pc = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) it.rs1 = {$urandom, $urandom};
      end else if (roll < 63) begin
        // Noise: returns, offset jalr, or an arbitrary word.
        it = random_item(OP_EVENT);
        case ($urandom_range(0, 3))
          0: it.word = RET_C_JR_RA;
          1: it.word = RET_JALR_RA;
          2: it.word = {12'($urandom_range(1, 4095)), 5'($urandom), 3'b000,
                        5'($urandom), JALR_MAJOR};
          default: ;
        endcase
      end else if (roll < 78) begin
        it = random_item(OP_READ_JUMP);
      end else if (roll < 95) begin
        it = random_item(OP_READ_SLOT);
      end else begin
        it = random_item(OP_IGNORED);
      end

      // Halfway through, hold off until every outstanding result is back.
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end

      send_item(it);
      if (it.op != OP_IGNORED) sent++;
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // A few more cycles, so that a stray extra result would still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ijtp_pkg.sv
rtl/ijtp_jump_tab.sv
rtl/ijtp_slot_tab.sv
rtl/indirect_jump_target_profiler.sv
bench/tb.sv
